@@ sv/epp_pkg.sv @@
// shared types and constants for the equirectangular pixel projection
// holds the cordic arctangent table and the stage-to-stage side payload struct
// no dependencies
package epp_pkg;

    // cordic datapath width, wide enough for the gain-scaled magnitude
    localparam int XW = 42;
    localparam int ITERS = 31;

    localparam logic [25:0] GAIN_Q24 = 26'd27628053;
    localparam logic [11:0] PANO_COLS = 12'd3600;
    localparam logic [10:0] PANO_ROWS = 11'd1800;

    // configuration register indexes
    localparam logic [1:0] CFG_CORNER = 2'd0;
    localparam logic [1:0] CFG_COL_STEP = 2'd1;
    localparam logic [1:0] CFG_ROW_STEP = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic [23:0]          color;
        logic signed [XW-1:0] aux;
    } side_t;

    // atan(2^-i) with 2^32 per turn
    function automatic logic [31:0] atan_at(input int i);
        logic [31:0] v;
        begin
            unique case (i)
                0: v = 32'd536870912;
                1: v = 32'd316933406;
                2: v = 32'd167458907;
                3: v = 32'd85004756;
                4: v = 32'd42667331;
                5: v = 32'd21354465;
                6: v = 32'd10679838;
                7: v = 32'd5340245;
                8: v = 32'd2670163;
                9: v = 32'd1335087;
                10: v = 32'd667544;
                11: v = 32'd333772;
                12: v = 32'd166886;
                13: v = 32'd83443;
                14: v = 32'd41722;
                15: v = 32'd20861;
                16: v = 32'd10430;
                17: v = 32'd5215;
                18: v = 32'd2608;
                19: v = 32'd1304;
                20: v = 32'd652;
                21: v = 32'd326;
                22: v = 32'd163;
                23: v = 32'd81;
                24: v = 32'd41;
                25: v = 32'd20;
                26: v = 32'd10;
                27: v = 32'd5;
                28: v = 32'd3;
                default: v = 32'd1;
            endcase
            return v;
        end
    endfunction

endpackage

@@ sv/epp_cordic.sv @@
// pipelined vectoring cordic: one quadrant-fold stage then one register per rotation
// depends on epp_pkg
module epp_cordic
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic signed [epp_pkg::XW-1:0] x_in,
    input  logic signed [epp_pkg::XW-1:0] y_in,
    input  epp_pkg::side_t                side_in,
    output logic signed [epp_pkg::XW-1:0] mag,
    output logic [31:0]                   ang,
    output epp_pkg::side_t                side_out
);

    localparam int N = epp_pkg::ITERS;

    logic signed [epp_pkg::XW-1:0] x_reg [0:N];
    logic signed [epp_pkg::XW-1:0] y_reg [0:N];
    logic [31:0]                   a_reg [0:N];
    logic                          zero_reg [0:N];
    epp_pkg::side_t                side_reg [0:N];

    // fold left half-plane by negation, remember zero vector
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                a_reg[0] <= 32'h8000_0000;
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                a_reg[0] <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg[0] <= '0;
        else if (en)
            side_reg[0] <= side_in;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        localparam logic [31:0] AT = epp_pkg::atan_at(i);
        logic signed [epp_pkg::XW-1:0] xs;
        logic signed [epp_pkg::XW-1:0] ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    a_reg[i+1] <= a_reg[i] + AT;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    a_reg[i+1] <= a_reg[i] - AT;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_reg[i+1] <= '0;
            else if (en)
                side_reg[i+1] <= side_reg[i];
        end
    end

    assign mag = x_reg[N];
    assign ang = zero_reg[N] ? 32'd0 : a_reg[N];
    assign side_out = side_reg[N];

endmodule

@@ sv/equirect_pixel_projection.sv @@
// top level of the equirectangular pixel projection
// point setup, two pipelined cordic units and panorama scaling
// depends on epp_pkg and epp_cordic

// Takes one source pixel per clock and returns its panorama column, row and
// unchanged color. The pipeline is 69 register stages deep: three for the
// point setup (products, sum, gain multiply), 32 for the longitude cordic,
// 32 for the latitude cordic and two for scaling and output. Throughput is one
// transfer per clock; the whole pipeline holds while a finished result is
// stalled, so in_stall follows out_stall only when the output register is full.
// Write configuration (cfg_we/cfg_index/cfg_data) only while idle (unenforced).
module equirect_pixel_projection
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [62:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] source_column,
    input  logic [11:0] source_row,
    input  logic [23:0] pixel_color,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] pano_column,
    output logic [10:0] pano_row,
    output logic [23:0] pano_color
);

    localparam int XW = epp_pkg::XW;

    // configuration registers, packed x / y / z
    logic [62:0] corner_reg;
    logic [62:0] col_step_reg;
    logic [62:0] row_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg <= '0;
            col_step_reg <= '0;
            row_step_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                epp_pkg::CFG_CORNER: corner_reg <= cfg_data;
                epp_pkg::CFG_COL_STEP: col_step_reg <= cfg_data;
                epp_pkg::CFG_ROW_STEP: row_step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: everything moves unless the output holds a stalled result
    logic out_valid_reg;
    logic adv;

    assign adv = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // stage 1: per-component products
    logic signed [33:0] pc_reg [0:2];
    logic signed [33:0] pr_reg [0:2];
    logic signed [24:0] pk_reg [0:2];
    logic               v1_reg;
    logic [23:0]        c1_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_prod
        logic signed [20:0] ck;
        logic signed [20:0] sk;
        logic signed [20:0] rk;
        logic signed [12:0] col_s;
        logic signed [12:0] row_s;

        assign ck = $signed(corner_reg[21*k +: 21]);
        assign sk = $signed(col_step_reg[21*k +: 21]);
        assign rk = $signed(row_step_reg[21*k +: 21]);
        assign col_s = $signed({1'b0, source_column});
        assign row_s = $signed({1'b0, source_row});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pc_reg[k] <= 34'(col_s) * 34'(sk);
                pr_reg[k] <= 34'(row_s) * 34'(rk);
                pk_reg[k] <= $signed({ck, 4'b0000});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            c1_reg <= pixel_color;
    end

    // stage 2: point in q.19
    logic signed [35:0] p_reg [0:2];
    logic               v2_reg;
    logic [23:0]        c2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
                p_reg[k] <= 36'(pc_reg[k]) + 36'(pr_reg[k]) + 36'(pk_reg[k]);
            c2_reg <= c1_reg;
        end
    end

    // stage 3: y scaled by the cordic gain, x and z held for the first cordic
    logic signed [61:0] ykp_reg;
    logic signed [35:0] x3_reg;
    logic signed [35:0] z3_reg;
    logic               v3_reg;
    logic [23:0]        c3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ykp_reg <= 62'(p_reg[1]) * 62'($signed({1'b0, epp_pkg::GAIN_Q24}));
            x3_reg <= p_reg[0];
            z3_reg <= p_reg[2];
            c3_reg <= c2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // longitude cordic on (x, z); yk rides along
    epp_pkg::side_t        side1_in;
    epp_pkg::side_t        side1_out;
    logic signed [XW-1:0]  mag1;
    logic [31:0]           ang1;

    assign side1_in.valid = v3_reg;
    assign side1_in.color = c3_reg;
    assign side1_in.aux = XW'($signed(ykp_reg[61:24]));

    epp_cordic u_cordic_lon
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .x_in     (XW'(x3_reg)),
        .y_in     (XW'(z3_reg)),
        .side_in  (side1_in),
        .mag      (mag1),
        .ang      (ang1),
        .side_out (side1_out)
    );

    // latitude cordic on (yk, magnitude); longitude rides along
    epp_pkg::side_t        side2_in;
    epp_pkg::side_t        side2_out;
    logic signed [XW-1:0]  mag2;
    logic [31:0]           ang2;
    logic [31:0]           lon;

    assign lon = 32'd0 - ang1;
    assign side2_in.valid = side1_out.valid;
    assign side2_in.color = side1_out.color;
    assign side2_in.aux = $signed({{(XW-32){1'b0}}, lon});

    epp_cordic u_cordic_lat
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .x_in     (side1_out.aux),
        .y_in     (mag1),
        .side_in  (side2_in),
        .mag      (mag2),
        .ang      (ang2),
        .side_out (side2_out)
    );

    // scaling stage: angle times panorama size
    logic [43:0] colp_reg;
    logic [41:0] rowp_reg;
    logic        v4_reg;
    logic [23:0] c4_reg;
    logic [30:0] lat_pos;

    // negative latitude from cordic error counts as zero
    assign lat_pos = ang2[31] ? 31'd0 : ang2[30:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            colp_reg <= 44'(side2_out.aux[31:0]) * 44'(epp_pkg::PANO_COLS);
            rowp_reg <= 42'(lat_pos) * 42'(epp_pkg::PANO_ROWS);
            c4_reg <= side2_out.color;
        end
    end

    // output stage: truncate and clamp, with the row index flipped top to bottom
    logic [11:0] col_idx;
    logic [10:0] row_idx;
    logic [11:0] col_next;
    logic [10:0] row_next;
    logic [11:0] pano_column_reg;
    logic [10:0] pano_row_reg;
    logic [23:0] pano_color_reg;

    assign col_idx = colp_reg[43:32];
    assign row_idx = rowp_reg[41:31];

    always_comb
    begin
        if (col_idx > epp_pkg::PANO_COLS - 12'd1)
            col_next = epp_pkg::PANO_COLS - 12'd1;
        else
            col_next = col_idx;
        if (row_idx > epp_pkg::PANO_ROWS - 11'd1)
            row_next = '0;
        else
            row_next = epp_pkg::PANO_ROWS - 11'd1 - row_idx;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pano_column_reg <= col_next;
            pano_row_reg <= row_next;
            pano_color_reg <= c4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= side2_out.valid;
            out_valid_reg <= v4_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pano_column = pano_column_reg;
    assign pano_row = pano_row_reg;
    assign pano_color = pano_color_reg;

endmodule
